FILE: rtl/core/usaq_pkg.sv
// Package with shared types, constants and codes for the upload slot admission queue.
`timescale 1ns / 1ps
package usaq_pkg;

    localparam int SLOTS_DEF      = 4;
    localparam int WAIT_DEPTH_DEF = 16;

    localparam logic [31:0] BUDGET_RST   = 32'd268435456;
    localparam logic [31:0] MAXSIZE_RST  = 32'd104857600;
    localparam logic [15:0] WAIT_TO_RST  = 16'd60;
    localparam logic [15:0] SLOT_TO_RST  = 16'd120;

    // Opcodes of an input item.
    localparam logic [2:0] OP_REQUEST    = 3'd0;
    localparam logic [2:0] OP_RELEASE    = 3'd1;
    localparam logic [2:0] OP_TICK       = 3'd2;
    localparam logic [2:0] OP_DISCONNECT = 3'd3;
    localparam logic [2:0] OP_DATA       = 3'd4;

    // Result kinds.
    localparam logic [2:0] K_GRANTED   = 3'd0;
    localparam logic [2:0] K_QUEUED    = 3'd1;
    localparam logic [2:0] K_BAD_SIZE  = 3'd2;
    localparam logic [2:0] K_FULL      = 3'd3;
    localparam logic [2:0] K_WAIT_TO   = 3'd4;
    localparam logic [2:0] K_DATA_OK   = 3'd5;
    localparam logic [2:0] K_DATA_BAD  = 3'd6;
    localparam logic [2:0] K_DONE      = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BUDGET  = 2'd0;
    localparam logic [1:0] CFG_MAXSIZE = 2'd1;
    localparam logic [1:0] CFG_WAIT_TO = 2'd2;
    localparam logic [1:0] CFG_SLOT_TO = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  client_id;
        logic [15:0] file_id;
        logic [31:0] request_size;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_client;
        logic [15:0] out_file;
        logic [1:0]  slot_index;
        logic [4:0]  queue_position;
        logic [31:0] granted_size;
        logic        last;
    } t_out_item;

    // Payload of one queue cell.
    typedef struct packed {
        logic [7:0]  owner;
        logic [15:0] file;
        logic [31:0] bytes;
        logic [31:0] since;
    } t_wait_entry;

    // Commands broadcast from the controller to every queue cell.
    typedef struct packed {
        logic        push;      // write the push entry at the tail
        logic        drop_head; // remove the head cell, shifting the rest down
        logic        rotate;    // head moves to tail, rest shift down
    } t_wait_cmd;

endpackage

FILE: rtl/core/upload_slot_admission_queue_unit.sv
// Top level of the upload slot admission queue: controller, slot table and queue chain.
`timescale 1ns / 1ps
// One item is worked on at a time and input stalls until it is finished. The wait
// queue is a chain of cells that shifts by one place a cycle while the scan is not
// held by output stall; a tick or disconnect rotates the whole queue once through
// its head, dropping expired or matching entries on the way. Each promotion from
// the queue passes through an empty scan state so that the registered byte sum
// catches up. Results leave through a single output register.
module upload_slot_admission_queue_unit
    import usaq_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW = 32 + SW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PROMO = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    // Configuration registers.
    logic [31:0] r_budget, r_maxsize;
    logic [15:0] r_wait_to, r_slot_to;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget  <= BUDGET_RST;
            r_maxsize <= MAXSIZE_RST;
            r_wait_to <= WAIT_TO_RST;
            r_slot_to <= SLOT_TO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BUDGET:  r_budget  <= i_cfg_data;
                CFG_MAXSIZE: r_maxsize <= i_cfg_data;
                CFG_WAIT_TO: r_wait_to <= i_cfg_data[15:0];
                CFG_SLOT_TO: r_slot_to <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Slot table and control state.
    logic [SLOTS-1:0] r_busy, n_busy;
    logic [7:0]  r_sown  [SLOTS], n_sown  [SLOTS];
    logic [15:0] r_sfile [SLOTS], n_sfile [SLOTS];
    logic [31:0] r_sbytes[SLOTS], n_sbytes[SLOTS];
    logic [31:0] r_sstart[SLOTS], n_sstart[SLOTS];
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic [31:0] r_now, n_now;
    logic [2:0]  r_state, n_state, r_after, n_after;
    t_in_item    r_item, n_item;
    logic [BW-1:0] r_used, n_used;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;

    t_wait_cmd   w_cmd;
    t_wait_entry w_push, w_head;

    usaq_wait_chain #(.WAIT_DEPTH(WAIT_DEPTH)) u_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .i_count(r_count),
        .i_push (w_push),
        .o_head (w_head)
    );

    // Lowest free slot, and the in-flight byte sum registered to keep the path short.
    logic [SW-1:0] w_free;
    logic          w_any_free;
    logic [BW-1:0] w_sum;
    always_comb begin
        w_free = '0;
        w_any_free = 1'b0;
        w_sum = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                w_free = SW'(i);
                w_any_free = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (r_busy[i]) w_sum = w_sum + BW'(r_sbytes[i]);
        end
    end

    // Matching slot for release and data items.
    logic [SW-1:0] w_hit;
    logic          w_any_hit;
    always_comb begin
        w_hit = '0;
        w_any_hit = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_busy[i] && r_sown[i] == r_item.client_id
                    && r_sfile[i] == r_item.file_id) begin
                w_hit = SW'(i);
                w_any_hit = 1'b1;
            end
        end
    end

    logic w_out_free;
    assign w_out_free = !r_ovalid || !i_out_stall;

    assign w_push = '{owner: r_item.client_id, file: r_item.file_id,
                      bytes: r_item.request_size, since: r_now};

    // Controller.
    always_comb begin
        logic [31:0] age;
        logic [SW:0] slot_w;
        n_busy = r_busy; n_sown = r_sown; n_sfile = r_sfile;
        n_sbytes = r_sbytes; n_sstart = r_sstart;
        n_count = r_count; n_left = r_left; n_now = r_now;
        n_state = r_state; n_after = r_after; n_item = r_item;
        n_used = w_sum;
        n_ovalid = r_ovalid && i_out_stall;
        n_out = r_out;
        w_cmd = '0;
        age = r_now - w_head.since;
        slot_w = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // Byte sum now registered for this item's state.
                n_state = S_IDLE;
                if (w_out_free) begin
                    n_out = '0;
                    n_out.out_client = r_item.client_id;
                    n_out.out_file = r_item.file_id;
                    n_out.last = 1'b1;
                    case (r_item.opcode)
                        OP_REQUEST: begin
                            n_ovalid = 1'b1;
                            if (r_item.request_size == 32'd0
                                    || r_item.request_size > r_maxsize) begin
                                n_out.kind = K_BAD_SIZE;
                            end else if (w_any_free && r_used + BW'(r_item.request_size)
                                    <= BW'(r_budget)) begin
                                n_busy[w_free] = 1'b1;
                                n_sown[w_free] = r_item.client_id;
                                n_sfile[w_free] = r_item.file_id;
                                n_sbytes[w_free] = r_item.request_size;
                                n_sstart[w_free] = r_now;
                                n_out.kind = K_GRANTED;
                                n_out.slot_index = 2'(w_free);
                                n_out.granted_size = r_item.request_size;
                            end else if (r_count < CW'(WAIT_DEPTH)) begin
                                w_cmd.push = 1'b1;
                                n_count = r_count + 1'b1;
                                n_out.kind = K_QUEUED;
                                n_out.queue_position = 5'(r_count + 1'b1);
                                n_out.granted_size = r_item.request_size;
                            end else begin
                                n_out.kind = K_FULL;
                            end
                        end
                        OP_RELEASE: begin
                            // One empty scan pass lets the byte sum see the freed slot.
                            if (w_any_hit) n_busy[w_hit] = 1'b0;
                            n_ovalid = 1'b0;
                            n_left = '0;
                            n_after = S_PROMO;
                            n_state = S_SCAN;
                        end
                        OP_TICK: begin
                            n_now = r_now + 1'b1;
                            for (int i = 0; i < SLOTS; i++) begin
                                if (r_busy[i] && (r_now + 32'd1 - r_sstart[i])
                                        > {16'd0, r_slot_to}) n_busy[i] = 1'b0;
                            end
                            n_ovalid = 1'b0;
                            n_left = r_count;
                            n_after = S_PROMO;
                            n_state = S_SCAN;
                        end
                        OP_DISCONNECT: begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (r_busy[i] && r_sown[i] == r_item.client_id)
                                    n_busy[i] = 1'b0;
                            end
                            n_ovalid = 1'b0;
                            n_left = r_count;
                            n_after = S_DONE;
                            n_state = S_SCAN;
                        end
                        OP_DATA: begin
                            n_ovalid = 1'b1;
                            if (w_any_hit) begin
                                n_sstart[w_hit] = r_now;
                                n_out.kind = K_DATA_OK;
                            end else begin
                                n_out.kind = K_DATA_BAD;
                            end
                        end
                        default: n_ovalid = 1'b0;
                    endcase
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_SCAN: begin
                // Bar a stall, an entry a cycle passes the head: kept ones go to the tail.
                if (r_left == '0) begin
                    n_state = r_after;
                end else if (r_item.opcode == OP_TICK && age > {16'd0, r_wait_to}) begin
                    if (w_out_free) begin
                        n_ovalid = 1'b1;
                        n_out = '0;
                        n_out.kind = K_WAIT_TO;
                        n_out.out_client = w_head.owner;
                        n_out.out_file = w_head.file;
                        w_cmd.drop_head = 1'b1;
                        n_count = r_count - 1'b1;
                        n_left = r_left - 1'b1;
                    end
                end else if (r_item.opcode == OP_DISCONNECT
                        && w_head.owner == r_item.client_id) begin
                    w_cmd.drop_head = 1'b1;
                    n_count = r_count - 1'b1;
                    n_left = r_left - 1'b1;
                end else begin
                    w_cmd.rotate = 1'b1;
                    n_left = r_left - 1'b1;
                end
            end
            S_PROMO: begin
                // Promote the head while a slot is free and it fits the budget.
                if (r_count != '0 && w_any_free
                        && r_used + BW'(w_head.bytes) <= BW'(r_budget)) begin
                    if (w_out_free) begin
                        slot_w = {1'b0, w_free};
                        n_busy[w_free] = 1'b1;
                        n_sown[w_free] = w_head.owner;
                        n_sfile[w_free] = w_head.file;
                        n_sbytes[w_free] = w_head.bytes;
                        n_sstart[w_free] = r_now;
                        n_ovalid = 1'b1;
                        n_out = '0;
                        n_out.kind = K_GRANTED;
                        n_out.out_client = w_head.owner;
                        n_out.out_file = w_head.file;
                        n_out.slot_index = 2'(slot_w);
                        n_out.granted_size = w_head.bytes;
                        w_cmd.drop_head = 1'b1;
                        n_count = r_count - 1'b1;
                        n_state = S_SCAN;
                        n_left = '0;
                        n_after = S_PROMO;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.kind = K_DONE;
                    n_out.out_client = r_item.client_id;
                    n_out.out_file = r_item.file_id;
                    n_out.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= '0;
            r_count  <= '0;
            r_now    <= '0;
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_left   <= '0;
            r_after  <= S_DONE;
        end else begin
            r_busy   <= n_busy;
            r_count  <= n_count;
            r_now    <= n_now;
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_left   <= n_left;
            r_after  <= n_after;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sown   <= n_sown;
        r_sfile  <= n_sfile;
        r_sbytes <= n_sbytes;
        r_sstart <= n_sstart;
        r_item   <= n_item;
        r_used   <= n_used;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/core/usaq_wait_cell.sv
// One cell of the wait queue: holds an entry and takes its upper neighbor's on a shift.
`timescale 1ns / 1ps
module usaq_wait_cell
    import usaq_pkg::*;
(
    input  logic        i_clk,
    input  t_wait_cmd   i_cmd,
    input  logic        i_is_tail,   // this cell is the first free place
    input  logic        i_is_last,   // this cell is the last valid one
    input  t_wait_entry i_push,
    input  t_wait_entry i_upper,     // entry of the next cell up
    input  t_wait_entry i_head,      // entry of cell zero
    output t_wait_entry o_entry
);

    t_wait_entry r_entry;
    t_wait_entry n_entry;

    // Shift down on a removal or rotation; the rotated head lands in the last valid cell.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.push && i_is_tail) begin
            n_entry = i_push;
        end else if (i_cmd.rotate) begin
            n_entry = i_is_last ? i_head : i_upper;
        end else if (i_cmd.drop_head) begin
            n_entry = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: rtl/core/usaq_wait_chain.sv
// The wait queue as a chain of cells with a shared fill count.
`timescale 1ns / 1ps
module usaq_wait_chain
    import usaq_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    localparam int CW = $clog2(WAIT_DEPTH + 1)
) (
    input  logic        i_clk,
    input  t_wait_cmd   i_cmd,
    input  logic [CW-1:0] i_count,
    input  t_wait_entry i_push,
    output t_wait_entry o_head
);

    t_wait_entry w_entry [WAIT_DEPTH+1];

    // The slot above the top cell feeds a don't-care entry.
    assign w_entry[WAIT_DEPTH] = i_push;

    for (genvar g = 0; g < WAIT_DEPTH; g++) begin : g_cell
        usaq_wait_cell u_cell (
            .i_clk    (i_clk),
            .i_cmd    (i_cmd),
            .i_is_tail(i_count == CW'(g)),
            .i_is_last(i_count == CW'(g + 1)),
            .i_push   (i_push),
            .i_upper  (w_entry[g+1]),
            .i_head   (w_entry[0]),
            .o_entry  (w_entry[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

FILE: rtl/core/usaq_checker.sv
// Port-level checker for the upload slot admission queue, bound to the top level.
`timescale 1ns / 1ps
module usaq_checker
    import usaq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed under stall");

    // An accepted item closes input until its work is under way.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input reopened at once");

    // Only grants carry a slot index.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != K_GRANTED |-> o_out_item.slot_index == 2'd0)
        else $error("slot index on non-grant");

    // Only queued results carry a position.
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != K_QUEUED |-> o_out_item.queue_position == 5'd0)
        else $error("position on non-queued result");

endmodule

bind upload_slot_admission_queue_unit usaq_checker u_usaq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the upload slot admission queue unit.
`timescale 1ns / 1ps
module tb_top;
    import usaq_pkg::*;

    localparam int  N_SLOTS     = 4;
    localparam int  N_WAIT      = 16;
    localparam int  SETTLE      = 2 * N_WAIT + N_SLOTS + 30;
    localparam int  CYCLE_LIMIT = 600000;

    // Idle modes of a phase.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    upload_slot_admission_queue_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Shadow copy of the admission state.
    logic [31:0]  cfg_budget;
    logic [31:0]  cfg_max_size;
    logic [15:0]  cfg_wait_to;
    logic [15:0]  cfg_slot_to;
    logic         sh_busy    [N_SLOTS];
    logic [7:0]   sh_owner   [N_SLOTS];
    logic [15:0]  sh_file    [N_SLOTS];
    logic [31:0]  sh_bytes   [N_SLOTS];
    logic [31:0]  sh_started [N_SLOTS];
    t_wait_entry  sh_waitq[$];
    logic [31:0]  sh_seconds;

    t_out_item    pending_results[$];
    int           err_cnt;
    int           idle_mode;
    longint       cycle_cnt;

    // Results of the item being predicted.
    t_out_item    step_res[$];

    function automatic void add_result(logic [2:0] kind, logic [7:0] cl, logic [15:0] fi,
                                       logic [1:0] slot, logic [4:0] pos, logic [31:0] sz);
        t_out_item r;
        r.kind           = kind;
        r.out_client     = cl;
        r.out_file       = fi;
        r.slot_index     = slot;
        r.queue_position = pos;
        r.granted_size   = sz;
        r.last           = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic int lowest_free_slot();
        for (int i = 0; i < N_SLOTS; i++)
            if (!sh_busy[i]) return i;
        return -1;
    endfunction

    function automatic bit size_fits(logic [31:0] sz);
        longint unsigned total;
        total = 0;
        for (int i = 0; i < N_SLOTS; i++)
            if (sh_busy[i]) total += sh_bytes[i];
        return (total + sz) <= longint'(cfg_budget);
    endfunction

    function automatic void claim_slot(int s, logic [7:0] cl, logic [15:0] fi,
                                       logic [31:0] sz);
        sh_busy[s]    = 1'b1;
        sh_owner[s]   = cl;
        sh_file[s]    = fi;
        sh_bytes[s]   = sz;
        sh_started[s] = sh_seconds;
    endfunction

    // Move queue heads into free slots while they fit.
    function automatic void promote_waiting();
        int s;
        while (sh_waitq.size() > 0) begin
            s = lowest_free_slot();
            if (s < 0 || !size_fits(sh_waitq[0].bytes)) break;
            claim_slot(s, sh_waitq[0].owner, sh_waitq[0].file, sh_waitq[0].bytes);
            add_result(K_GRANTED, sh_waitq[0].owner, sh_waitq[0].file, s[1:0], 5'd0,
                       sh_waitq[0].bytes);
            void'(sh_waitq.pop_front());
        end
    endfunction

    // Compute the results of one accepted item into step_res.
    function automatic void predict_admission(t_in_item it);
        int          s;
        int          k;
        t_wait_entry we;
        t_out_item   r;
        step_res.delete();
        case (it.opcode)
            OP_REQUEST: begin
                s = lowest_free_slot();
                if (it.request_size == 0 || it.request_size > cfg_max_size) begin
                    add_result(K_BAD_SIZE, it.client_id, it.file_id, 2'd0, 5'd0, 32'd0);
                end else if (s >= 0 && size_fits(it.request_size)) begin
                    claim_slot(s, it.client_id, it.file_id, it.request_size);
                    add_result(K_GRANTED, it.client_id, it.file_id, s[1:0], 5'd0,
                               it.request_size);
                end else if (sh_waitq.size() < N_WAIT) begin
                    we.owner = it.client_id;
                    we.file  = it.file_id;
                    we.bytes = it.request_size;
                    we.since = sh_seconds;
                    sh_waitq.push_back(we);
                    add_result(K_QUEUED, it.client_id, it.file_id, 2'd0,
                               5'(sh_waitq.size()), it.request_size);
                end else begin
                    add_result(K_FULL, it.client_id, it.file_id, 2'd0, 5'd0, 32'd0);
                end
            end
            OP_RELEASE: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (sh_busy[i] && sh_owner[i] == it.client_id &&
                        sh_file[i] == it.file_id) begin
                        sh_busy[i] = 1'b0;
                        break;
                    end
                end
                promote_waiting();
                add_result(K_DONE, it.client_id, it.file_id, 2'd0, 5'd0, 32'd0);
            end
            OP_TICK: begin
                sh_seconds = sh_seconds + 32'd1;
                for (int i = 0; i < N_SLOTS; i++)
                    if (sh_busy[i] && (sh_seconds - sh_started[i]) > 32'(cfg_slot_to))
                        sh_busy[i] = 1'b0;
                k = 0;
                while (k < sh_waitq.size()) begin
                    if ((sh_seconds - sh_waitq[k].since) > 32'(cfg_wait_to)) begin
                        add_result(K_WAIT_TO, sh_waitq[k].owner, sh_waitq[k].file,
                                   2'd0, 5'd0, 32'd0);
                        sh_waitq.delete(k);
                    end else begin
                        k++;
                    end
                end
                promote_waiting();
                add_result(K_DONE, it.client_id, it.file_id, 2'd0, 5'd0, 32'd0);
            end
            OP_DISCONNECT: begin
                for (int i = 0; i < N_SLOTS; i++)
                    if (sh_busy[i] && sh_owner[i] == it.client_id) sh_busy[i] = 1'b0;
                k = 0;
                while (k < sh_waitq.size()) begin
                    if (sh_waitq[k].owner == it.client_id) sh_waitq.delete(k);
                    else k++;
                end
                add_result(K_DONE, it.client_id, it.file_id, 2'd0, 5'd0, 32'd0);
            end
            OP_DATA: begin
                s = -1;
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (sh_busy[i] && sh_owner[i] == it.client_id &&
                        sh_file[i] == it.file_id) begin
                        sh_started[i] = sh_seconds;
                        s = i;
                        break;
                    end
                end
                add_result((s >= 0) ? K_DATA_OK : K_DATA_BAD, it.client_id, it.file_id,
                           2'd0, 5'd0, 32'd0);
            end
            default: ;
        endcase
        if (step_res.size() > 0) begin
            r = step_res.pop_back();
            r.last = 1'b1;
            step_res.push_back(r);
        end
    endfunction

    // Receiver stall, redrawn every cycle.
    always @(negedge i_clk) begin
        if (idle_mode == IDLE_RECV)
            i_out_stall <= ($urandom_range(0, 99) < 63);
        else if (idle_mode == IDLE_BOTH)
            i_out_stall <= ($urandom_range(0, 99) < 35);
        else
            i_out_stall <= 1'b0;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: %p", o_out_item);
                err_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (o_out_item.kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_out_item.kind);
                    err_cnt++;
                end
                if (o_out_item.out_client !== e.out_client) begin
                    $error("out_client: expected %0d, got %0d", e.out_client,
                           o_out_item.out_client);
                    err_cnt++;
                end
                if (o_out_item.out_file !== e.out_file) begin
                    $error("out_file: expected %0d, got %0d", e.out_file,
                           o_out_item.out_file);
                    err_cnt++;
                end
                if (o_out_item.slot_index !== e.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", e.slot_index,
                           o_out_item.slot_index);
                    err_cnt++;
                end
                if (o_out_item.queue_position !== e.queue_position) begin
                    $error("queue_position: expected %0d, got %0d", e.queue_position,
                           o_out_item.queue_position);
                    err_cnt++;
                end
                if (o_out_item.granted_size !== e.granted_size) begin
                    $error("granted_size: expected %0d, got %0d", e.granted_size,
                           o_out_item.granted_size);
                    err_cnt++;
                end
                if (o_out_item.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_out_item.last);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one item and return once it has been accepted.
    task automatic send_item(t_in_item it);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 63 : (idle_mode == IDLE_BOTH) ? 35 : 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < gap_pct) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until every expected result is in, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BUDGET:  cfg_budget   = val;
            CFG_MAXSIZE: cfg_max_size = val;
            CFG_WAIT_TO: cfg_wait_to  = val[15:0];
            default:     cfg_slot_to  = val[15:0];
        endcase
    endtask

    task automatic configure(logic [31:0] budget, logic [31:0] maxsz, logic [15:0] wto,
                             logic [15:0] sto);
        write_reg(CFG_BUDGET, budget);
        write_reg(CFG_MAXSIZE, maxsz);
        write_reg(CFG_WAIT_TO, {16'd0, wto});
        write_reg(CFG_SLOT_TO, {16'd0, sto});
    endtask

    // Accept one item into the predictor and queue its results.
    task automatic issue(t_in_item it);
        send_item(it);
        predict_admission(it);
        foreach (step_res[i]) pending_results.push_back(step_res[i]);
    endtask

    // Directed table: item plus an optional single result typed in by hand.
    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic void add_row(logic [2:0] op, logic [7:0] cl, logic [15:0] fi,
                                    logic [31:0] sz, bit typed, logic [2:0] kind,
                                    logic [1:0] slot, logic [4:0] pos, logic [31:0] gsz);
        t_dir_row r;
        r.it.opcode       = op;
        r.it.client_id    = cl;
        r.it.file_id      = fi;
        r.it.request_size = sz;
        r.typed              = typed;
        r.res.kind           = kind;
        r.res.out_client     = cl;
        r.res.out_file       = fi;
        r.res.slot_index     = slot;
        r.res.queue_position = pos;
        r.res.granted_size   = gsz;
        r.res.last           = 1'b1;
        dir_rows.push_back(r);
    endfunction

    // Random item, biased toward live clients and files so that events hit.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        int       s;
        longint unsigned cap;
        pick = $urandom_range(0, 99);
        it.opcode = (pick < 40) ? OP_REQUEST : (pick < 55) ? OP_RELEASE :
                    (pick < 75) ? OP_TICK : (pick < 80) ? OP_DISCONNECT :
                    (pick < 93) ? OP_DATA : 3'($urandom_range(5, 7));
        it.client_id    = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom);
        it.file_id      = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 3))
                                                       : 16'($urandom);
        it.request_size = $urandom;
        if (it.opcode == OP_REQUEST) begin
            pick = $urandom_range(0, 99);
            cap  = (cfg_max_size < cfg_budget) ? cfg_max_size : cfg_budget;
            cap  = cap / 2 + 1;
            if (pick < 6)       it.request_size = 32'd0;
            else if (pick < 12) it.request_size = $urandom;
            else if (pick < 17) it.request_size = cfg_max_size;
            else it.request_size = $urandom_range(1, 32'(cap));
        end else if ((it.opcode == OP_RELEASE || it.opcode == OP_DATA) &&
                     $urandom_range(0, 99) < 60) begin
            s = $urandom_range(0, N_SLOTS - 1);
            if (sh_busy[s]) begin
                it.client_id = sh_owner[s];
                it.file_id   = sh_file[s];
            end
        end
        return it;
    endfunction

    task automatic random_phase(int mode, int count);
        idle_mode = mode;
        repeat (count) issue(random_item());
        drain();
    endtask

    // Main sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_BUDGET;
        i_cfg_data  = '0;
        err_cnt     = 0;
        idle_mode   = IDLE_NONE;
        cycle_cnt   = 0;
        cfg_budget   = BUDGET_RST;
        cfg_max_size = MAXSIZE_RST;
        cfg_wait_to  = WAIT_TO_RST;
        cfg_slot_to  = SLOT_TO_RST;
        for (int i = 0; i < N_SLOTS; i++) sh_busy[i] = 1'b0;
        sh_seconds = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        // Directed part under the reset settings.
        add_row(OP_REQUEST, 8'd1, 16'd1, 32'd0, 1, K_BAD_SIZE, 2'd0, 5'd0, 32'd0);
        add_row(OP_REQUEST, 8'd1, 16'd1, 32'hFFFF_FFFF, 1, K_BAD_SIZE, 2'd0, 5'd0, 32'd0);
        add_row(OP_REQUEST, 8'd1, 16'd1, MAXSIZE_RST, 1, K_GRANTED, 2'd0, 5'd0,
                MAXSIZE_RST);
        add_row(OP_REQUEST, 8'd2, 16'd2, MAXSIZE_RST, 1, K_GRANTED, 2'd1, 5'd0,
                MAXSIZE_RST);
        add_row(OP_REQUEST, 8'd3, 16'd3, MAXSIZE_RST, 1, K_QUEUED, 2'd0, 5'd1,
                MAXSIZE_RST);
        // A small request still fits while a large one waits.
        add_row(OP_REQUEST, 8'd4, 16'd4, 32'd1, 1, K_GRANTED, 2'd2, 5'd0, 32'd1);
        add_row(OP_DATA, 8'd1, 16'd1, 32'd0, 1, K_DATA_OK, 2'd0, 5'd0, 32'd0);
        add_row(OP_DATA, 8'hFF, 16'hFFFF, 32'd0, 1, K_DATA_BAD, 2'd0, 5'd0, 32'd0);
        add_row(OP_RELEASE, 8'd1, 16'd1, 32'd0, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(OP_RELEASE, 8'd7, 16'd7, 32'd0, 1, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(3'd5, 8'd2, 16'd2, 32'd0, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(3'd6, 8'd2, 16'd2, 32'd0, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(3'd7, 8'd2, 16'd2, 32'd0, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(OP_REQUEST, 8'hFF, 16'hFFFF, MAXSIZE_RST, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(OP_REQUEST, 8'h80, 16'h8000, MAXSIZE_RST, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(OP_TICK, 8'd0, 16'd0, 32'd0, 1, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(OP_DISCONNECT, 8'd3, 16'd9, 32'd0, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(OP_DISCONNECT, 8'hFF, 16'd0, 32'd0, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        add_row(OP_RELEASE, 8'd2, 16'd2, 32'hFFFF_FFFF, 0, K_DONE, 2'd0, 5'd0, 32'd0);
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].it);
            predict_admission(dir_rows[i].it);
            if (dir_rows[i].typed) pending_results.push_back(dir_rows[i].res);
            else foreach (step_res[j]) pending_results.push_back(step_res[j]);
        end
        drain();

        // Random phases over several settings, extremes among them.
        configure(32'd1000, 32'd400, 16'd3, 16'd5);
        random_phase(IDLE_SEND, 65);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        random_phase(IDLE_RECV, 60);
        configure(32'd1, 32'd1, 16'd1, 16'd1);
        random_phase(IDLE_BOTH, 60);
        configure(32'd3000, 32'd2000, 16'd2, 16'd4);
        random_phase(IDLE_NONE, 85);

        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
